### sv/bssdp_pkg.sv
`default_nettype none
package bssdp_pkg;

  // parser phase
  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_ID   = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  localparam logic [7:0] HEADER_BYTE = 8'h40;
  localparam logic [7:0] ID_PACKET   = 8'h00;
  localparam logic [7:0] ID_BATTERY  = 8'h01;
  localparam logic [7:0] ID_TEMP     = 8'h02;
  localparam logic [7:0] ID_HUMID    = 8'h03;
  localparam logic [7:0] ID_VOLTAGE  = 8'h0C;

  localparam logic [1:0] KIND_BATTERY = 2'd0;
  localparam logic [1:0] KIND_TEMP    = 2'd1;
  localparam logic [1:0] KIND_HUMID   = 2'd2;

  localparam int VALUE_W = 13;

  // x/10 = (x*52429)>>19, exact for x < 262144
  // x/100 = (x*83887)>>23, exact for x < 91180
  localparam logic [16:0] RECIP_10  = 17'd52429;
  localparam logic [16:0] RECIP_100 = 17'd83887;

  // queue between parser and arithmetic back end
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one decoded measurement on its way to the back end
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] raw;
  } op_t;

endpackage
`default_nettype wire

### sv/bssdp_if.sv
`default_nettype none
interface bssdp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output first_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input data_byte, input first_byte, input last_byte,
                  output ready);
endinterface

interface bssdp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         reading_kind;
  logic signed [12:0] reading_value;

  modport source (output valid, output reading_kind, output reading_value, input ready);
  modport sink   (input valid, input reading_kind, input reading_value, output ready);
endinterface
`default_nettype wire

### sv/bssdp_front.sv
`default_nettype none
module bssdp_front import bssdp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  bssdp_in_if.sink    in_ch,
  input  logic        q_full,
  output logic        push,
  output op_t         push_op
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  object_id_r, object_id_nxt;
  logic [1:0]  bytes_left_r, bytes_left_nxt;
  logic [7:0]  low_byte_r, low_byte_nxt;
  logic        accept;
  logic        emit;
  logic [7:0]  b;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign b           = in_ch.data_byte;

  always_comb begin
    phase_nxt      = phase_r;
    object_id_nxt  = object_id_r;
    bytes_left_nxt = bytes_left_r;
    low_byte_nxt   = low_byte_r;
    emit           = 1'b0;
    push_op.kind   = KIND_BATTERY;
    push_op.raw    = {b, low_byte_r};
    if (accept) begin
      if (in_ch.first_byte) begin
        phase_nxt      = (b == HEADER_BYTE && !in_ch.last_byte) ? PH_ID : PH_WAIT;
        bytes_left_nxt = 2'd0;
      end else begin
        case (phase_r)
          PH_ID: begin
            object_id_nxt = b;
            if (b == ID_PACKET || b == ID_BATTERY) begin
              bytes_left_nxt = 2'd1;
              phase_nxt      = in_ch.last_byte ? PH_WAIT : PH_DATA;
            end else if (b == ID_TEMP || b == ID_HUMID || b == ID_VOLTAGE) begin
              bytes_left_nxt = 2'd2;
              phase_nxt      = in_ch.last_byte ? PH_WAIT : PH_DATA;
            end else begin
              // unknown id ends the packet
              bytes_left_nxt = 2'd0;
              phase_nxt      = PH_WAIT;
            end
          end
          PH_DATA: begin
            if (bytes_left_r == 2'd2) begin
              low_byte_nxt   = b;
              bytes_left_nxt = 2'd1;
              if (in_ch.last_byte) phase_nxt = PH_WAIT;
            end else begin
              bytes_left_nxt = 2'd0;
              phase_nxt      = in_ch.last_byte ? PH_WAIT : PH_ID;
              case (object_id_r)
                ID_BATTERY: begin
                  emit         = 1'b1;
                  push_op.kind = KIND_BATTERY;
                  push_op.raw  = {8'd0, b};
                end
                ID_TEMP: begin
                  emit         = 1'b1;
                  push_op.kind = KIND_TEMP;
                end
                ID_HUMID: begin
                  emit         = 1'b1;
                  push_op.kind = KIND_HUMID;
                end
                default: emit = 1'b0;
              endcase
            end
          end
          default: phase_nxt = PH_WAIT;
        endcase
      end
    end
  end

  assign push = emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_WAIT;
      object_id_r  <= 8'd0;
      bytes_left_r <= 2'd0;
      low_byte_r   <= 8'd0;
    end else begin
      phase_r      <= phase_nxt;
      object_id_r  <= object_id_nxt;
      bytes_left_r <= bytes_left_nxt;
      low_byte_r   <= low_byte_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/bssdp_queue.sv
`default_nettype none
module bssdp_queue import bssdp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  output logic pop_valid,
  output op_t  pop_op,
  input  logic pop
);

  op_t               entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_pop;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_op    = entry_r[rd_ptr_r];
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/bssdp_back.sv
`default_nettype none
module bssdp_back import bssdp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        op_valid,
  input  op_t         op,
  output logic        pop,
  bssdp_out_if.source out_ch
);

  // stage 1: rounding offset, magnitude and reciprocal multiply
  logic               s1_v_r;
  logic [1:0]         s1_kind_r;
  logic               s1_neg_r;
  logic [32:0]        s1_prod_r;
  logic [7:0]         s1_byte_r;

  // stage 2: output register
  logic               o_v_r;
  logic [1:0]         o_kind_r;
  logic [VALUE_W-1:0] o_value_r;

  logic               o_free;
  logic               s1_adv;
  logic signed [16:0] sum;
  logic [16:0]        neg_sum;
  logic               neg;
  logic [15:0]        mag;
  logic [16:0]        recip;
  logic [32:0]        prod;
  logic [VALUE_W-1:0] quot;
  logic [VALUE_W-1:0] value_nxt;

  assign o_free = !o_v_r || out_ch.ready;
  assign s1_adv = !s1_v_r || o_free;
  assign pop    = op_valid && s1_adv;

  always_comb begin
    sum     = $signed({op.raw[15], op.raw}) + 17'sd5;
    neg_sum = 17'(-sum);
    neg     = (op.kind == KIND_TEMP) && sum[16];
    if (op.kind == KIND_TEMP) begin
      mag   = neg ? neg_sum[15:0] : sum[15:0];
      recip = RECIP_10;
    end else begin
      mag   = op.raw;
      recip = RECIP_100;
    end
    prod = 33'(mag) * 33'(recip);
  end

  always_comb begin
    case (s1_kind_r)
      KIND_TEMP:  quot = s1_prod_r[31:19];
      KIND_HUMID: quot = {3'd0, s1_prod_r[32:23]};
      default:    quot = {5'd0, s1_byte_r};
    endcase
    value_nxt = s1_neg_r ? (~quot + 1'b1) : quot;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_kind_r <= op.kind;
      s1_neg_r  <= neg;
      s1_prod_r <= prod;
      s1_byte_r <= op.raw[7:0];
    end
    if (o_free && s1_v_r) begin
      o_kind_r  <= s1_kind_r;
      o_value_r <= value_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (s1_adv) s1_v_r <= op_valid;
      if (o_free) o_v_r  <= s1_v_r;
    end
  end

  assign out_ch.valid         = o_v_r;
  assign out_ch.reading_kind  = o_kind_r;
  assign out_ch.reading_value = $signed(o_value_r);

endmodule
`default_nettype wire

### sv/ble_sensor_service_data_parser.sv
// Parses the service data of a sensor advertisement, one byte per transaction
// on in_ch, with first_byte on the header and last_byte on the final byte. Packets
// whose header is not 0x40 are dropped. Battery, temperature and humidity
// objects each give one transaction on out_ch: kind 0 battery percent, kind 1
// temperature in tenths of a degree ((raw+5)/10, truncated toward zero), kind 2
// humidity percent (raw/100). Packet-id and voltage objects are skipped; an
// unknown id ends the packet; an object cut off by last_byte gives nothing.
// Throughput is one byte per clock. in_ready drops only when the two-entry
// queue between the parser and the arithmetic back end is full, which happens
// only when out_ch is stalled. A result passes from the queue write on the edge
// that takes its last byte through the multiply stage and then the output
// register before it is offered on out_ch.
`default_nettype none
module ble_sensor_service_data_parser import bssdp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  bssdp_in_if.sink    in_ch,
  bssdp_out_if.source out_ch
);

  // parser -> queue
  logic push;
  op_t  push_op;
  logic q_full;

  // queue -> back end
  logic op_valid;
  op_t  op;
  logic pop;

  // front: byte classification and object walk
  bssdp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .push    (push),
    .push_op (push_op)
  );

  // decouples byte intake from output stalls
  bssdp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_op   (push_op),
    .full      (q_full),
    .pop_valid (op_valid),
    .pop_op    (op),
    .pop       (pop)
  );

  // back: constant divisions by reciprocal multiply, then output register
  bssdp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .op_valid (op_valid),
    .op       (op),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire

### sv/bssdp_checker.sv
`default_nettype none
module bssdp_checker import bssdp_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         reading_kind,
  input logic signed [12:0] reading_value
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> reading_kind != 2'd3)
    else $error("illegal reading kind");

  a_battery_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && reading_kind == KIND_BATTERY |-> reading_value[12:8] == 5'd0)
    else $error("battery value out of range");

  a_humid_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && reading_kind == KIND_HUMID |->
      !reading_value[12] && reading_value <= 13'sd655)
    else $error("humidity value out of range");

  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result shown right after reset");

endmodule

bind ble_sensor_service_data_parser bssdp_checker u_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .reading_kind  (out_ch.reading_kind),
  .reading_value (out_ch.reading_value)
);
`default_nettype wire

### bench/ble_sensor_reading_checker.sv
module ble_sensor_reading_checker import bssdp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  bssdp_in_if   in_mon,
  bssdp_out_if  out_mon,
  output int    fail_count,
  output int    pending
);

  typedef struct {
    logic [1:0]         kind;
    logic signed [12:0] value;
  } reading_t;

  // parser state, tracked independently of the block
  phase_t     phase;
  logic [7:0] cur_id;
  logic [1:0] left;
  logic [7:0] lo;

  reading_t readings_due[$];

  // Advance the parser by one byte; returns 1 when a reading completes.
  function automatic bit decode_byte(input logic [7:0] b, input bit f, input bit l,
                                     output reading_t r);
    logic [15:0] word;
    int          t;
    bit          got;
    got = 1'b0;
    r.kind = KIND_BATTERY;
    r.value = '0;
    if (f) begin
      phase = (b == HEADER_BYTE && !l) ? PH_ID : PH_WAIT;
      left = 2'd0;
    end else if (phase == PH_ID) begin
      cur_id = b;
      if (b == ID_PACKET || b == ID_BATTERY) begin
        left = 2'd1;
        phase = l ? PH_WAIT : PH_DATA;
      end else if (b == ID_TEMP || b == ID_HUMID || b == ID_VOLTAGE) begin
        left = 2'd2;
        phase = l ? PH_WAIT : PH_DATA;
      end else begin
        // unknown id kills the rest of the packet
        phase = PH_WAIT;
        left = 2'd0;
      end
    end else if (phase == PH_DATA) begin
      if (left == 2'd2) begin
        lo = b;
        left = 2'd1;
        if (l) phase = PH_WAIT;
      end else begin
        left = 2'd0;
        word = {b, lo};
        case (cur_id)
          ID_BATTERY: begin
            r.kind = KIND_BATTERY;
            r.value = 13'(int'(b));
            got = 1'b1;
          end
          ID_TEMP: begin
            t = $signed(word);
            t = (t + 5) / 10;   // truncates toward zero
            r.kind = KIND_TEMP;
            r.value = 13'(t);
            got = 1'b1;
          end
          ID_HUMID: begin
            t = int'(word) / 100;
            r.kind = KIND_HUMID;
            r.value = 13'(t);
            got = 1'b1;
          end
          default: ;
        endcase
        phase = l ? PH_WAIT : PH_ID;
      end
    end else begin
      phase = PH_WAIT;
    end
    return got;
  endfunction

  always @(posedge clk) begin
    reading_t r;
    reading_t want;
    if (!rst_n) begin
      phase = PH_WAIT;
      cur_id = '0;
      left = '0;
      lo = '0;
      readings_due.delete();
      fail_count = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        if (decode_byte(in_mon.data_byte, in_mon.first_byte, in_mon.last_byte, r))
          readings_due.push_back(r);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (readings_due.size() == 0) begin
          $error("unexpected reading: reading_kind=%0d reading_value=%0d",
                 out_mon.reading_kind, out_mon.reading_value);
          fail_count++;
        end else begin
          want = readings_due.pop_front();
          if (out_mon.reading_kind !== want.kind) begin
            $error("reading_kind: expected %0d, actual %0d", want.kind,
                   out_mon.reading_kind);
            fail_count++;
          end
          if (out_mon.reading_value !== want.value) begin
            $error("reading_value: expected %0d, actual %0d", want.value,
                   out_mon.reading_value);
            fail_count++;
          end
        end
      end
    end
    pending = readings_due.size();
  end

endmodule

### bench/ble_sensor_service_data_parser_tb.sv
// Stimulus and verdict for the service-data parser. All prediction and
// comparison lives in ble_sensor_reading_checker; this module only feeds
// bytes, works the result-side ready and decides pass or fail.
module ble_sensor_service_data_parser_tb;
  import bssdp_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  // codes the block does not know, used to hit the reject paths
  localparam logic [7:0] BAD_HEADER = 8'h41;
  localparam logic [7:0] UNKNOWN_ID = 8'h05;

  localparam int RANDOM_ITEMS = 1650;
  localparam int LONG_HOLD    = 400;   // receiver stall while the sender streams
  localparam int DRAIN_CYCLES = 40;    // covers the back-end pipeline plus receiver stalls

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;

  // knobs set by the main sequence: tx_no_gaps for the sender, hold_req for the receiver
  bit tx_no_gaps;
  bit hold_req;

  bssdp_in_if  in_ch();
  bssdp_out_if out_ch();

  ble_sensor_service_data_parser uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  ble_sensor_reading_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #(12 * 400000);
    $display("Some tests failed");
    $finish;
  end

  // One byte transaction. The gap is taken first with valid low; valid then
  // rises at a falling edge and holds until the rising edge that takes it.
  task automatic put_byte(input logic [7:0] b, input bit f, input bit l);
    int gap;
    gap = tx_no_gaps ? 0 : $urandom_range(0, 15);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.first_byte <= f;
    in_ch.last_byte  <= l;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Start mark on byte 0; end mark on the final byte only when close is set.
  // An unclosed packet is abandoned by whatever start mark comes next.
  task automatic send_packet(input byte_q_t pkt, input bit close);
    for (int i = 0; i < pkt.size(); i++)
      put_byte(pkt[i], i == 0, close && (i == pkt.size() - 1));
  endtask

  // 16-bit payloads: half fully random, half near the rounding and range edges
  function automatic logic [15:0] pick_raw();
    logic [15:0] corners[12];
    corners = '{16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'hFFFB, 16'hFFFA,
                16'h0004, 16'h0005, 16'hFFF1, 16'd99, 16'd100, 16'h8005};
    if ($urandom_range(0, 1) == 0)
      return 16'($urandom);
    if ($urandom_range(0, 1) == 0)
      return corners[$urandom_range(0, 11)];
    return 16'($urandom_range(0, 100)) - 16'd50;
  endfunction

  // Builds and sends one mostly well-formed packet with random content;
  // returns how many bytes went out.
  task automatic random_packet(output int n_sent);
    byte_q_t     pkt;
    logic [7:0]  id;
    logic [15:0] raw;
    int          cut;
    bit          close;
    pkt = {};
    n_sent = 0;
    // stray bytes between packets
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        put_byte(8'($urandom), 1'b0, 1'($urandom));
        n_sent++;
      end
    end
    pkt.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : HEADER_BYTE);
    repeat ($urandom_range(0, 6)) begin
      case ($urandom_range(0, 11))
        0:       id = ID_PACKET;
        1, 2:    id = ID_BATTERY;
        3, 4, 5: id = ID_TEMP;
        6, 7:    id = ID_HUMID;
        8:       id = ID_VOLTAGE;
        9:       id = 8'($urandom);
        10:      id = UNKNOWN_ID;
        default: id = ID_TEMP;
      endcase
      pkt.push_back(id);
      raw = pick_raw();
      if (id == ID_PACKET || id == ID_BATTERY) begin
        pkt.push_back(raw[7:0]);
      end else if (id == ID_TEMP || id == ID_HUMID || id == ID_VOLTAGE) begin
        pkt.push_back(raw[7:0]);
        pkt.push_back(raw[15:8]);
      end else begin
        // trailing junk after an unknown id
        repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom));
      end
    end
    // cut short: end mark can land mid-object
    if (pkt.size() > 1 && $urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, pkt.size() - 1);
      pkt = pkt[0:cut-1];
    end
    close = ($urandom_range(0, 11) != 0);
    send_packet(pkt, close);
    n_sent += pkt.size();
  endtask

  // Result side: per result a random stall 0..15, sometimes none at all, and
  // once a long hold so the internal queue fills and in_ready drops.
  initial begin
    int  w;
    bit  rx_no_gaps;
    bit  hold_done;
    rx_no_gaps = 1'b0;
    hold_done = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 19) == 0) rx_no_gaps = ~rx_no_gaps;
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        w = LONG_HOLD;
      end else begin
        w = rx_no_gaps ? 0 : $urandom_range(0, 15);
      end
      repeat (w) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // Main sequence: reset, directed packets, random packets, drain, verdict.
  initial begin
    byte_q_t pkt;
    int      sent;
    int      n;
    int      pkt_count;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.first_byte = 1'b0;
    in_ch.last_byte  = 1'b0;
    tx_no_gaps       = 1'b0;
    hold_req         = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- directed ---
    // stray byte carrying an end mark while waiting: ignored
    put_byte(8'hFF, 1'b0, 1'b1);
    // bad header: whole packet dropped
    pkt = '{BAD_HEADER, ID_BATTERY, 8'h64};
    send_packet(pkt, 1'b1);
    // header only, start and end mark on the same byte
    pkt = '{HEADER_BYTE};
    send_packet(pkt, 1'b1);
    // every object kind; temperature at both range ends, humidity at max
    pkt = '{HEADER_BYTE, ID_PACKET, 8'h7F, ID_BATTERY, 8'hFF,
            ID_TEMP, 8'hFF, 8'h7F, ID_TEMP, 8'h00, 8'h80,
            ID_HUMID, 8'hFF, 8'hFF, ID_VOLTAGE, 8'h12, 8'h34};
    send_packet(pkt, 1'b1);
    // -5 rounds to 0, then an object cut short by the end mark on its id
    pkt = '{HEADER_BYTE, ID_TEMP, 8'hFB, 8'hFF, ID_HUMID};
    send_packet(pkt, 1'b1);
    // unknown id: the battery after it must not show up
    pkt = '{HEADER_BYTE, UNKNOWN_ID, ID_BATTERY, 8'h22};
    send_packet(pkt, 1'b1);
    // payload cut short, then a packet abandoned by a new start mark
    pkt = '{HEADER_BYTE, ID_TEMP, 8'h10};
    send_packet(pkt, 1'b1);
    pkt = '{HEADER_BYTE, ID_BATTERY};
    send_packet(pkt, 1'b0);
    pkt = '{HEADER_BYTE, ID_BATTERY, 8'h00};
    send_packet(pkt, 1'b1);

    // --- random ---
    // Open with a back-to-back burst while the receiver sits on a long hold.
    sent = 0;
    pkt_count = 0;
    hold_req = 1'b1;
    tx_no_gaps = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      random_packet(n);
      sent += n;
      pkt_count++;
      if (pkt_count > 40 && $urandom_range(0, 15) == 0) tx_no_gaps = ~tx_no_gaps;
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;

    // wait out every expected reading, then give stray output a chance to show
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
